### sv/doubleword_mul_div_unit_assert.svh
// Assertion macros for the doubleword multiply/divide unit.
`ifndef DOUBLEWORD_MUL_DIV_UNIT_ASSERT_SVH
`define DOUBLEWORD_MUL_DIV_UNIT_ASSERT_SVH

// Antecedent in the same cycle implies consequent.
`define DMDU_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("dmdu check failed");

// Antecedent implies consequent in the next cycle.
`define DMDU_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("dmdu check failed");

`endif

### sv/dmdu_pkg.sv
// ----------------------------------------------------------------------------
// dmdu_pkg
// Types and operation codes shared by the doubleword multiply/divide unit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package dmdu_pkg;

    localparam int WORD_W  = 64;
    localparam int HALF_W  = 32;
    localparam int DIV_STEPS = WORD_W;

    localparam logic [1:0] OP_SMUL = 2'd0;
    localparam logic [1:0] OP_UMUL = 2'd1;
    localparam logic [1:0] OP_SDIV = 2'd2;
    localparam logic [1:0] OP_UDIV = 2'd3;

    localparam logic [WORD_W-1:0] MIN_SIGNED = {1'b1, {(WORD_W-1){1'b0}}};

    typedef struct packed {
        logic [1:0]        operation;
        logic [WORD_W-1:0] operand_a;
        logic [WORD_W-1:0] operand_b;
    } req_t;

    typedef struct packed {
        logic [WORD_W-1:0] lo_word;
        logic [WORD_W-1:0] hi_word;
    } rsp_t;

    // Data carried through the divide stages; multiplies ride along untouched.
    typedef struct packed {
        logic              is_div;
        logic              neg_q;
        logic              neg_r;
        logic [WORD_W-1:0] rem;
        logic [WORD_W-1:0] quo;
        logic [WORD_W-1:0] dvs;
    } pipe_t;

    typedef struct packed {
        logic [1:0]        operation;
        logic [WORD_W-1:0] op_a;
        logic [WORD_W-1:0] op_b;
        logic [WORD_W-1:0] mag_a;
        logic [WORD_W-1:0] mag_b;
        logic              neg_q;
        logic              neg_r;
        logic [WORD_W-1:0] p00;
        logic [WORD_W-1:0] p01;
        logic [WORD_W-1:0] p10;
        logic [WORD_W-1:0] p11;
    } prep_t;

endpackage

### sv/doubleword_mul_div_unit.sv
// ----------------------------------------------------------------------------
// doubleword_mul_div_unit
// 64x64 signed/unsigned multiply to a 128-bit hi/lo pair, and 64-bit
// signed/unsigned divide giving quotient (lo) and remainder (hi).
// ----------------------------------------------------------------------------
//  channel   signals                      direction
//  request   req_valid, req_stall, req    in (stall out)
//  response  rsp_valid, rsp_stall, rsp    out (stall in)
//
//  Stages: input register, operand prep with four 32x32 partial
//  products, product sum, high-word correction, 64 restoring divide steps
//  (one quotient bit each), sign fix / output register.
//  One request per cycle unless req_stall is set. A stage advances
//  when its successor is free, so bubbles close up under rsp_stall.
//  rst_n clears only the valid bits.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module doubleword_mul_div_unit (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_stall,
    input  dmdu_pkg::req_t req,
    output logic          rsp_valid,
    input  logic          rsp_stall,
    output dmdu_pkg::rsp_t rsp
);
    import dmdu_pkg::*;

    localparam int NDV = DIV_STEPS + 1;

    // valid bits
    logic           in_vld_reg, s1_vld_reg, s2_vld_reg, out_vld_reg;
    logic [NDV-1:0] dv_vld_reg;

    // ready chain
    logic           in_rdy, s1_rdy, s2_rdy, out_rdy;
    logic [NDV-1:0] dv_rdy;

    req_t  in_reg;
    prep_t s1_reg, s1_next;
    pipe_t s2_reg, s2_next;
    logic [WORD_W-1:0] corr_reg, corr_next;
    pipe_t dv_reg [NDV];
    pipe_t dv_next [NDV];
    rsp_t  out_reg, out_next;

    assign out_rdy = !out_vld_reg || !rsp_stall;
    assign dv_rdy[NDV-1] = !dv_vld_reg[NDV-1] || out_rdy;
    genvar g;
    generate
        for (g = 0; g < NDV-1; g++) begin : g_rdy
            assign dv_rdy[g] = !dv_vld_reg[g] || dv_rdy[g+1];
        end
    endgenerate
    assign s2_rdy = !s2_vld_reg || dv_rdy[0];
    assign s1_rdy = !s1_vld_reg || s2_rdy;
    assign in_rdy = !in_vld_reg || s1_rdy;

    assign req_stall = !in_rdy;
    assign rsp_valid = out_vld_reg;
    assign rsp       = out_reg;

    // stage 1: divisor fix, magnitudes, partial products
    logic [WORD_W-1:0] a1, b1, bfix;
    logic              sdiv1, na1, nb1;
    always_comb
    begin
        a1    = in_reg.operand_a;
        b1    = in_reg.operand_b;
        sdiv1 = (in_reg.operation == OP_SDIV);
        bfix  = b1;
        if (b1 == '0 || (sdiv1 && a1 == MIN_SIGNED && b1 == '1))
        begin
            bfix = {{(WORD_W-1){1'b0}}, 1'b1};
        end
        na1 = sdiv1 && a1[WORD_W-1];
        nb1 = sdiv1 && bfix[WORD_W-1];
        s1_next.operation = in_reg.operation;
        s1_next.op_a  = a1;
        s1_next.op_b  = b1;
        s1_next.mag_a = na1 ? (WORD_W'(0) - a1) : a1;
        s1_next.mag_b = nb1 ? (WORD_W'(0) - bfix) : bfix;
        s1_next.neg_q = na1 ^ nb1;
        s1_next.neg_r = na1;
        s1_next.p00 = a1[HALF_W-1:0] * b1[HALF_W-1:0];
        s1_next.p01 = a1[HALF_W-1:0] * b1[WORD_W-1:HALF_W];
        s1_next.p10 = a1[WORD_W-1:HALF_W] * b1[HALF_W-1:0];
        s1_next.p11 = a1[WORD_W-1:HALF_W] * b1[WORD_W-1:HALF_W];
    end

    // stage 2: sum partial products, or seed the divider
    logic [WORD_W-1:0] mid2, ca2, cb2;
    logic              smul2, div2;
    always_comb
    begin
        smul2 = (s1_reg.operation == OP_SMUL);
        div2  = (s1_reg.operation == OP_SDIV) || (s1_reg.operation == OP_UDIV);
        mid2  = {{HALF_W{1'b0}}, s1_reg.p00[WORD_W-1:HALF_W]}
              + {{HALF_W{1'b0}}, s1_reg.p01[HALF_W-1:0]}
              + {{HALF_W{1'b0}}, s1_reg.p10[HALF_W-1:0]};
        ca2 = (smul2 && s1_reg.op_a[WORD_W-1]) ? s1_reg.op_b : '0;
        cb2 = (smul2 && s1_reg.op_b[WORD_W-1]) ? s1_reg.op_a : '0;
        corr_next = ca2 + cb2;
        s2_next.is_div = div2;
        s2_next.neg_q  = s1_reg.neg_q;
        s2_next.neg_r  = s1_reg.neg_r;
        s2_next.dvs    = s1_reg.mag_b;
        if (div2)
        begin
            s2_next.rem = '0;
            s2_next.quo = s1_reg.mag_a;
        end
        else
        begin
            s2_next.quo = {mid2[HALF_W-1:0], s1_reg.p00[HALF_W-1:0]};
            s2_next.rem = s1_reg.p11
                        + {{HALF_W{1'b0}}, s1_reg.p01[WORD_W-1:HALF_W]}
                        + {{HALF_W{1'b0}}, s1_reg.p10[WORD_W-1:HALF_W]}
                        + {{HALF_W{1'b0}}, mid2[WORD_W-1:HALF_W]};
        end
    end

    // stage 3: signed high-word correction
    always_comb
    begin
        dv_next[0] = s2_reg;
        if (!s2_reg.is_div)
        begin
            dv_next[0].rem = s2_reg.rem - corr_reg;
        end
    end

    // restoring divide, one quotient bit per stage
    generate
        for (g = 0; g < DIV_STEPS; g++) begin : g_step
            logic [WORD_W:0] rr, diff;
            always_comb
            begin
                rr   = {dv_reg[g].rem, dv_reg[g].quo[WORD_W-1]};
                diff = rr - {1'b0, dv_reg[g].dvs};
                dv_next[g+1] = dv_reg[g];
                if (dv_reg[g].is_div)
                begin
                    if (!diff[WORD_W])
                    begin
                        dv_next[g+1].rem = diff[WORD_W-1:0];
                        dv_next[g+1].quo = {dv_reg[g].quo[WORD_W-2:0], 1'b1};
                    end
                    else
                    begin
                        dv_next[g+1].rem = rr[WORD_W-1:0];
                        dv_next[g+1].quo = {dv_reg[g].quo[WORD_W-2:0], 1'b0};
                    end
                end
            end
        end
    endgenerate

    // sign fix
    always_comb
    begin
        out_next.lo_word = dv_reg[NDV-1].neg_q ? (WORD_W'(0) - dv_reg[NDV-1].quo)
                                               : dv_reg[NDV-1].quo;
        out_next.hi_word = dv_reg[NDV-1].neg_r ? (WORD_W'(0) - dv_reg[NDV-1].rem)
                                               : dv_reg[NDV-1].rem;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg  <= 1'b0;
            s1_vld_reg  <= 1'b0;
            s2_vld_reg  <= 1'b0;
            dv_vld_reg  <= '0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            if (in_rdy)
            begin
                in_vld_reg <= req_valid;
            end
            if (s1_rdy)
            begin
                s1_vld_reg <= in_vld_reg;
            end
            if (s2_rdy)
            begin
                s2_vld_reg <= s1_vld_reg;
            end
            if (dv_rdy[0])
            begin
                dv_vld_reg[0] <= s2_vld_reg;
            end
            for (int k = 1; k < NDV; k++)
            begin
                if (dv_rdy[k])
                begin
                    dv_vld_reg[k] <= dv_vld_reg[k-1];
                end
            end
            if (out_rdy)
            begin
                out_vld_reg <= dv_vld_reg[NDV-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_rdy)
        begin
            in_reg <= req;
        end
        if (s1_rdy)
        begin
            s1_reg <= s1_next;
        end
        if (s2_rdy)
        begin
            s2_reg   <= s2_next;
            corr_reg <= corr_next;
        end
        for (int k = 0; k < NDV; k++)
        begin
            if (dv_rdy[k])
            begin
                dv_reg[k] <= dv_next[k];
            end
        end
        if (out_rdy)
        begin
            out_reg <= out_next;
        end
    end

endmodule

### sv/dmdu_checker.sv
// ----------------------------------------------------------------------------
// dmdu_checker
// Port-level checks for the doubleword multiply/divide unit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "doubleword_mul_div_unit_assert.svh"

module dmdu_port_checker (
    input logic           clk,
    input logic           rst_n,
    input logic           req_valid,
    input logic           req_stall,
    input dmdu_pkg::req_t req,
    input logic           rsp_valid,
    input logic           rsp_stall,
    input dmdu_pkg::rsp_t rsp
);
    import dmdu_pkg::*;

    // request side only backs up when the whole pipe is full and blocked
    `DMDU_ASSERT_IMP(a_stall_needs_full, req_stall, rsp_valid && rsp_stall)
    `DMDU_ASSERT_IMP(a_free_out_no_stall, !rsp_stall, !req_stall)
    `DMDU_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp))

endmodule

bind doubleword_mul_div_unit dmdu_port_checker u_dmdu_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
);
